// ===== design/atipd_pkg.sv =====
// ----------------------------------------------------------------------------
// atipd_pkg
// Shared types and constants for the modem response and data frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package atipd_pkg;

	localparam int LINE_BUF   = 256;
	localparam int LINKS      = 5;
	localparam int MASK_W     = 5;
	localparam int LINE_CNT_W = $clog2(LINE_BUF + 1);
	localparam int LINE_LEN_W = 9;
	localparam int LLEN_W     = (LINE_CNT_W > LINE_LEN_W) ? LINE_CNT_W : LINE_LEN_W;
	localparam int RECENT_W   = 56;

	localparam logic [1:0] ADDR_OPEN_MASK = 2'd0;

	localparam logic [7:0]  CH_COMMA = ",";
	localparam logic [7:0]  CH_COLON = ":";
	localparam logic [7:0]  CH_LF    = 8'h0A;
	localparam logic [7:0]  CH_ZERO  = "0";
	localparam logic [7:0]  CH_NINE  = "9";
	localparam logic [39:0] IPD_TAG  = "+IPD,";
	localparam logic [31:0] OK_TAG   = "OK\r\n";
	localparam logic [55:0] ERR_TAG  = "ERROR\r\n";

	typedef enum logic [2:0] {
		KIND_TEXT    = 3'd0,
		KIND_HEADER  = 3'd1,
		KIND_DELIVER = 3'd2,
		KIND_DROP    = 3'd3,
		KIND_ABORT   = 3'd4
	} kind_t;

	typedef struct packed {
		logic ipd;
		logic ok;
		logic error;
	} match_t;

	typedef struct packed {
		kind_t                  kind;
		logic [7:0]             data_byte;
		logic [7:0]             link_id;
		logic                   packet_end;
		logic                   line_end;
		logic [LINE_LEN_W-1:0]  line_length;
		logic                   status_valid;
		logic                   status_error;
	} result_t;

endpackage

`default_nettype wire

// ===== design/atipd_line_match.sv =====
// ----------------------------------------------------------------------------
// atipd_line_match
// Suffix compare of the current line against the frame tag and status words.
// ----------------------------------------------------------------------------
`default_nettype none

module atipd_line_match (
	input  wire logic [atipd_pkg::RECENT_W-1:0] recent,
	input  wire logic [2:0]                     avail,
	output atipd_pkg::match_t                   hit
);
	import atipd_pkg::*;

	always_comb begin
		hit.ipd   = (avail >= 3'd5) && (recent[39:0] == IPD_TAG);
		hit.ok    = (avail >= 3'd4) && (recent[31:0] == OK_TAG);
		hit.error = (avail == 3'd7) && (recent[55:0] == ERR_TAG);
	end

endmodule

`default_nettype wire

// ===== design/atipd_parser.sv =====
// ----------------------------------------------------------------------------
// atipd_parser
// Parse state and one-byte step logic: line tracking, header decode, payload.
// ----------------------------------------------------------------------------
`default_nettype none

module atipd_parser (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         advance,
	input  wire logic [7:0]                   rx_byte,
	input  wire logic [atipd_pkg::MASK_W-1:0] open_link_mask,
	output atipd_pkg::result_t                res
);
	import atipd_pkg::*;

	localparam int MASK_IDX_W = (MASK_W > 1) ? $clog2(MASK_W) : 1;

	typedef enum logic [2:0] {
		MODE_LINE,
		MODE_LINK,
		MODE_LEN,
		MODE_SKIP,
		MODE_DATA
	} mode_t;

	mode_t                  mode_q, mode_d;
	logic [RECENT_W-1:0]    rec_q, rec_d;
	logic [LINE_CNT_W-1:0]  cnt_q, cnt_d;
	logic [7:0]             link_q, link_d;
	logic [15:0]            len_q, len_d;
	logic [15:0]            seen_q, seen_d;
	logic                   open_q, open_d;

	logic [RECENT_W-1:0]    rec_shift;
	logic [LINE_CNT_W:0]    cnt_inc;
	logic [LINE_CNT_W-1:0]  cnt_wr;
	logic [LLEN_W-1:0]      cnt_ext;
	logic [2:0]             avail;
	match_t                 match;
	logic                   digit;
	logic [19:0]            len_ext;
	logic [19:0]            prod;
	logic [15:0]            len_acc;
	logic [7:0]             link_sat;

	function automatic logic lookup(input logic [7:0] link, input logic [MASK_W-1:0] mask);
		logic r;
		r = 1'b0;
		if (link < 8'(LINKS) && link < 8'(MASK_W)) begin
			r = mask[link[MASK_IDX_W-1:0]];
		end
		return r;
	endfunction

	assign rec_shift = {rec_q[RECENT_W-9:0], rx_byte};
	assign cnt_inc   = {1'b0, cnt_q} + (LINE_CNT_W+1)'(1);
	assign cnt_wr    = (cnt_inc >= (LINE_CNT_W+1)'(LINE_BUF)) ? '0 : cnt_inc[LINE_CNT_W-1:0];
	assign cnt_ext   = LLEN_W'(cnt_wr);
	assign avail     = (cnt_wr >= LINE_CNT_W'(7)) ? 3'd7 : cnt_wr[2:0];

	atipd_line_match u_match (
		.recent (rec_shift),
		.avail  (avail),
		.hit    (match)
	);

	assign digit    = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign len_ext  = {4'b0, len_q};
	assign prod     = (len_ext << 3) + (len_ext << 1) + {16'b0, rx_byte[3:0]};
	assign len_acc  = (prod > 20'd65535) ? 16'hFFFF : prod[15:0];
	assign link_sat = (len_q > 16'd255) ? 8'hFF : len_q[7:0];

	always_comb begin
		mode_d = mode_q;
		rec_d  = rec_q;
		cnt_d  = cnt_q;
		link_d = link_q;
		len_d  = len_q;
		seen_d = seen_q;
		open_d = open_q;

		res              = '0;
		res.kind         = KIND_HEADER;
		res.data_byte    = rx_byte;
		res.link_id      = link_q;

		unique case (mode_q)
			MODE_LINE: begin
				res.kind    = KIND_TEXT;
				res.link_id = 8'd0;
				rec_d       = rec_shift;
				cnt_d       = cnt_wr;
				if (match.ipd) begin
					res.kind = KIND_HEADER;
					mode_d   = MODE_LINK;
					cnt_d    = '0;
					rec_d    = '0;
					link_d   = 8'd0;
					len_d    = 16'd0;
					seen_d   = 16'd0;
					open_d   = 1'b0;
				end else if (rx_byte == CH_LF) begin
					res.line_end     = 1'b1;
					res.line_length  = (cnt_ext > LLEN_W'(511)) ? 9'd511
						: cnt_ext[LINE_LEN_W-1:0];
					res.status_valid = match.ok || match.error;
					res.status_error = !match.ok && match.error;
					cnt_d            = '0;
					rec_d            = '0;
				end
			end
			MODE_LINK: begin
				if (digit) begin
					len_d = len_acc;
				end else if (rx_byte == CH_COMMA) begin
					link_d = link_sat;
					len_d  = 16'd0;
					open_d = lookup(link_sat, open_link_mask);
					mode_d = MODE_LEN;
				end else if (rx_byte == CH_COLON && len_q != 16'd0) begin
					link_d = 8'd0;
					open_d = lookup(8'd0, open_link_mask);
					mode_d = MODE_DATA;
				end else begin
					res.kind = KIND_ABORT;
					mode_d   = MODE_LINE;
					cnt_d    = '0;
					rec_d    = '0;
				end
				res.link_id = link_d;
			end
			MODE_LEN: begin
				if (digit) begin
					len_d = len_acc;
				end else if ((rx_byte == CH_COMMA || rx_byte == CH_COLON)
					&& len_q != 16'd0) begin
					mode_d = (rx_byte == CH_COMMA) ? MODE_SKIP : MODE_DATA;
				end else begin
					res.kind = KIND_ABORT;
					mode_d   = MODE_LINE;
					cnt_d    = '0;
					rec_d    = '0;
				end
			end
			MODE_SKIP: begin
				if (rx_byte == CH_COLON) begin
					mode_d = MODE_DATA;
				end
			end
			MODE_DATA: begin
				res.kind = open_q ? KIND_DELIVER : KIND_DROP;
				seen_d   = seen_q + 16'd1;
				if (seen_d >= len_q) begin
					res.packet_end = 1'b1;
					mode_d         = MODE_LINE;
					cnt_d          = '0;
					rec_d          = '0;
				end
			end
			default: begin
				mode_d = MODE_LINE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LINE;
			rec_q  <= '0;
			cnt_q  <= '0;
			link_q <= 8'd0;
			len_q  <= 16'd0;
			seen_q <= 16'd0;
			open_q <= 1'b0;
		end else if (advance) begin
			mode_q <= mode_d;
			rec_q  <= rec_d;
			cnt_q  <= cnt_d;
			link_q <= link_d;
			len_q  <= len_d;
			seen_q <= seen_d;
			open_q <= open_d;
		end
	end

	a_data_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_DATA |-> len_q != 16'd0)
		else $error("payload mode with zero frame length");

	a_data_seen_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_DATA |-> seen_q < len_q)
		else $error("payload count reached frame length without leaving payload mode");

	a_open_link_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> link_q < 8'(LINKS))
		else $error("link marked open while out of range");

endmodule

`default_nettype wire

// ===== design/at_ipd_frame_and_reply_parser_core.sv =====
// ----------------------------------------------------------------------------
// at_ipd_frame_and_reply_parser_core
// Modem receive byte parser: response lines with status, +IPD data frames.
// ----------------------------------------------------------------------------
//  channel   | dir | contents
//  s_*       | in  | tdata[7:0] rx_byte
//  m_*       | out | tdata data_byte/link_id/line info, tuser kind, tlast packet_end
//  apb       | cfg | 0x0 open_link_mask[4:0]
//
//  one byte per cycle sustained while m_tready stays high; path from input to result:
//  input register, then parse step and result register; parse state
//  updates as the byte moves into the result register
//  m_tready low holds the result and one more byte in the input register
//  reset clears parse state, link mask and both valid flags
// ----------------------------------------------------------------------------
`default_nettype none

module at_ipd_frame_and_reply_parser_core (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte

	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [7:0] data_byte, [15:8] link_id, [16] line_end,
	                                    // [25:17] line_length, [26] status_valid,
	                                    // [27] status_error, [31:28] zero
	output logic [2:0]       m_tuser,   // [2:0] kind
	output logic             m_tlast,   // packet_end

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import atipd_pkg::*;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              valid_s2;
	result_t           res_s2;
	result_t           res;
	logic [MASK_W-1:0] mask_q;
	logic              advance;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_OPEN_MASK) ? {{(32-MASK_W){1'b0}}, mask_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_OPEN_MASK) begin
			mask_q <= pwdata[MASK_W-1:0];
		end
	end

	// stage handshake
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	atipd_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.rx_byte        (byte_s1),
		.open_link_mask (mask_q),
		.res            (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.kind;
	assign m_tlast  = res_s2.packet_end;
	assign m_tdata  = {4'b0, res_s2.status_error, res_s2.status_valid, res_s2.line_length,
		res_s2.line_end, res_s2.link_id, res_s2.data_byte};

	a_last_is_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tuser == KIND_DELIVER || m_tuser == KIND_DROP))
		else $error("packet end on a non-payload result");

	a_line_end_is_text: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.line_end |-> m_tuser == KIND_TEXT)
		else $error("line end on a non-text result");

	a_status_needs_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.status_valid |-> res_s2.line_end)
		else $error("status reported without line end");

endmodule

`default_nettype wire
